@@ rtl/bcd_pkg.sv @@
// Shared types, constants and helper functions for the Bayer crop, demosaic
// and color correction block. No dependencies.
`default_nettype none

package bcd_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;
  localparam int CROP_W     = 12;
  localparam int FMT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int QUOT_W     = 9;
  localparam int SUM_W      = 11;

  localparam logic [DIM_W-1:0] ROW_MAX = {DIM_W{1'b1}};

  // Constant division by reciprocal: q = (v * K) >> RECIP_SHIFT, with K the
  // term's multiplier folded into ceil(2^RECIP_SHIFT / divisor). Exact for
  // every 8-bit operand used here.
  localparam int RECIP_SHIFT = 18;
  localparam int K_W         = 19;
  localparam int PROD_W      = PIX_W + K_W;

  localparam logic [K_W-1:0] K_RED_G   = K_W'(7  * ((2**RECIP_SHIFT + 18) / 19));
  localparam logic [K_W-1:0] K_RED_B   = K_W'(14 * ((2**RECIP_SHIFT + 21) / 22));
  localparam logic [K_W-1:0] K_GREEN_G = K_W'(13 * ((2**RECIP_SHIFT + 9) / 10));
  localparam logic [K_W-1:0] K_GREEN_B = K_W'(6  * ((2**RECIP_SHIFT + 36) / 37));
  localparam logic [K_W-1:0] K_BLUE_R  = K_W'(5  * ((2**RECIP_SHIFT + 35) / 36));
  localparam logic [K_W-1:0] K_BLUE_G  = K_W'(2  * ((2**RECIP_SHIFT + 2) / 3));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_WIDTH    = 3'd0,
    REG_CROP_X       = 3'd1,
    REG_CROP_Y       = 3'd2,
    REG_OUT_WIDTH    = 3'd3,
    REG_OUT_HEIGHT   = 3'd4,
    REG_BAYER_FORMAT = 3'd5
  } cfg_reg_t;

  // Bayer phase of the window's top-left sample.
  typedef enum logic [FMT_W-1:0] {
    PH_BLUE_TL = 2'd0,
    PH_BLUE_TR = 2'd1,
    PH_RED_TR  = 2'd2,
    PH_RED_TL  = 2'd3
  } phase_t;

  function automatic logic [QUOT_W-1:0] recip_div(input logic [PIX_W-1:0] v,
                                                   input logic [K_W-1:0] k);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(k);
    return p[PROD_W-1:RECIP_SHIFT];
  endfunction

  function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SUM_W'(255))) begin
      r = {PIX_W{1'b1}};
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bcd_raw_if.sv @@
// Raw pixel stream channel: valid/ready plus one raw sample and frame mark.
// Depends on bcd_pkg for the pixel width.
`default_nettype none

interface bcd_raw_if;
  logic                      valid;
  logic                      ready;
  logic [bcd_pkg::PIX_W-1:0] raw_pixel;
  logic                      frame_start;

  modport source (output valid, output raw_pixel, output frame_start, input ready);
  modport sink   (input valid, input raw_pixel, input frame_start, output ready);
endinterface

`default_nettype wire

@@ rtl/bcd_rgb_if.sv @@
// RGB result stream channel: valid/ready plus corrected color and frame end.
// Depends on bcd_pkg for the pixel width.
`default_nettype none

interface bcd_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [bcd_pkg::PIX_W-1:0] red;
  logic [bcd_pkg::PIX_W-1:0] green;
  logic [bcd_pkg::PIX_W-1:0] blue;
  logic                      frame_last;

  modport source (output valid, output red, output green, output blue,
                  output frame_last, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/bayer_crop_demosaic_ccm.sv @@
// Bayer crop, 2x2 demosaic and fixed color correction, top level.
// Depends on bcd_pkg, bcd_raw_if and bcd_rgb_if.
//
//  channel | dir | payload                              | request moves when
//  --------+-----+--------------------------------------+---------------------------
//  raw     | in  | raw_pixel[7:0], frame_start          | raw.valid && raw.ready
//  rgb     | out | red[7:0], green[7:0], blue[7:0],     | rgb.valid && rgb.ready
//          |     | frame_last                           |
//  cfg     | in  | cfg_index[2:0], cfg_data[12:0]       | cfg_we
//
// Throughput: one raw request per clock while rgb.ready holds. A request
// goes from accept to rgb.valid through accept (position logic and row store
// read), color select and reciprocal multiplies, sums and clamp into the
// output register. The single-port row store (read-before-write at the same
// column) sets the one-request-per-cycle pace. Reset is synchronous; it clears
// counters, valid bits, configuration and left-neighbor registers but not the
// row store, which needs no clearing pass since its stale row 0 reads are never
// emitted. Stalls on rgb collapse bubbles stage by stage before raw.ready drops.
`default_nettype none

module bayer_crop_demosaic_ccm #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bcd_raw_if.sink                                 raw,
  bcd_rgb_if.source                               rgb,
  input  wire logic                               cfg_we,
  input  wire logic [bcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_LINE);
  localparam int WW    = $clog2(MAX_LINE + 1);
  localparam int EW    = (WW > bcd_pkg::DIM_W) ? WW : bcd_pkg::DIM_W;
  localparam int SZW   = bcd_pkg::DIM_W + 1;
  localparam int CMPW  = (EW > SZW) ? EW : SZW;
  localparam int PW    = bcd_pkg::PIX_W;
  localparam int QW    = bcd_pkg::QUOT_W;
  localparam int SW    = bcd_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bcd_pkg::DIM_W-1:0]  raw_width;
  logic [bcd_pkg::CROP_W-1:0] crop_x;
  logic [bcd_pkg::CROP_W-1:0] crop_y;
  logic [bcd_pkg::DIM_W-1:0]  out_width;
  logic [bcd_pkg::DIM_W-1:0]  out_height;
  logic [bcd_pkg::FMT_W-1:0]  bayer_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_width    <= bcd_pkg::DIM_W'(640);
      crop_x       <= '0;
      crop_y       <= '0;
      out_width    <= bcd_pkg::DIM_W'(320);
      out_height   <= bcd_pkg::DIM_W'(240);
      bayer_format <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcd_pkg::REG_RAW_WIDTH:    raw_width    <= cfg_data[bcd_pkg::DIM_W-1:0];
        bcd_pkg::REG_CROP_X:       crop_x       <= cfg_data[bcd_pkg::CROP_W-1:0];
        bcd_pkg::REG_CROP_Y:       crop_y       <= cfg_data[bcd_pkg::CROP_W-1:0];
        bcd_pkg::REG_OUT_WIDTH:    out_width    <= cfg_data[bcd_pkg::DIM_W-1:0];
        bcd_pkg::REG_OUT_HEIGHT:   out_height   <= cfg_data[bcd_pkg::DIM_W-1:0];
        bcd_pkg::REG_BAYER_FORMAT: bayer_format <= cfg_data[bcd_pkg::FMT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage advances when the one after it has room.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, out_valid;
  logic adv_out, adv2, adv1, accept;

  assign adv_out   = !out_valid || rgb.ready;
  assign adv2      = !s2_valid || adv_out;
  assign adv1      = !s1_valid || adv2;
  assign raw.ready = adv1;
  assign accept    = raw.valid && adv1;

  // ---------------------------------------------------------------------------
  // Accept stage: frame position, crop test and row store access.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]             column_count;
  logic [bcd_pkg::DIM_W-1:0] row_count;
  logic                      frame_done;

  logic [EW-1:0]             eff_w;
  logic [EW-1:0]             raw_w_ext;
  logic [EW-1:0]             col_ext;
  logic [EW-1:0]             c_full;
  logic [EW-1:0]             c_inc;
  logic [bcd_pkg::DIM_W-1:0] r_cur;
  logic                      fd_cur;
  logic [EW-1:0]             x_pos;
  logic [EW-1:0]             dx;
  logic [bcd_pkg::DIM_W-1:0] y_pos;
  logic [bcd_pkg::DIM_W-1:0] dy;
  logic [SZW-1:0]            wp;
  logic [SZW-1:0]            hp;
  logic                      in_x, in_y;
  logic                      acc_emit, acc_last;
  logic [bcd_pkg::FMT_W-1:0] acc_phase;
  logic [AW-1:0]             c_addr;
  logic [AW-1:0]             col_next;
  logic [bcd_pkg::DIM_W-1:0] row_next;

  always_comb begin
    raw_w_ext = EW'(raw_width);
    if (raw_w_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (raw_w_ext > EW'(MAX_LINE)) begin
      eff_w = EW'(MAX_LINE);
    end else begin
      eff_w = raw_w_ext;
    end

    // A frame mark restarts the position before this sample is placed.
    col_ext = raw.frame_start ? '0 : EW'(column_count);
    r_cur   = raw.frame_start ? '0 : row_count;
    fd_cur  = raw.frame_start ? 1'b0 : frame_done;

    // Hold the column inside a width that shrank since the last sample.
    c_full = (col_ext >= eff_w) ? (eff_w - EW'(1)) : col_ext;
    c_addr = c_full[AW-1:0];
    c_inc  = c_full + EW'(1);

    // Window's top-left corner and crop test; crop sizes round up to even.
    x_pos = c_full - EW'(1);
    y_pos = r_cur - bcd_pkg::DIM_W'(1);
    dx    = x_pos - EW'(crop_x);
    dy    = y_pos - bcd_pkg::DIM_W'(crop_y);
    wp    = (SZW'(out_width) + SZW'(1)) & ~SZW'(1);
    hp    = (SZW'(out_height) + SZW'(1)) & ~SZW'(1);
    in_x  = (x_pos >= EW'(crop_x)) && (CMPW'(dx) < CMPW'(wp));
    in_y  = (y_pos >= bcd_pkg::DIM_W'(crop_y)) && (CMPW'(dy) < CMPW'(hp));

    acc_emit  = (c_full != '0) && (r_cur != '0) && !fd_cur && in_x && in_y;
    acc_last  = (CMPW'(dx) == CMPW'(wp) - CMPW'(1)) &&
                (CMPW'(dy) == CMPW'(hp) - CMPW'(1));
    acc_phase = bayer_format ^ {y_pos[0], x_pos[0]};

    // Advance the raster position; the row count saturates.
    if (c_inc >= eff_w) begin
      col_next = '0;
      row_next = (r_cur < bcd_pkg::ROW_MAX) ? r_cur + bcd_pkg::DIM_W'(1) : r_cur;
    end else begin
      col_next = c_inc[AW-1:0];
      row_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      frame_done   <= 1'b0;
    end else if (accept) begin
      column_count <= col_next;
      row_count    <= row_next;
      frame_done   <= fd_cur || (acc_emit && acc_last);
    end
  end

  // Previous raw row: read the old sample and write the new one at one column.
  logic [PW-1:0] row_store [MAX_LINE];
  logic [PW-1:0] above_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      above_rd          <= row_store[c_addr];
      row_store[c_addr] <= raw.raw_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: demosaic select and reciprocal multiplies.
  // ---------------------------------------------------------------------------
  logic          s1_emit, s1_last;
  logic [bcd_pkg::FMT_W-1:0] s1_phase;
  logic [PW-1:0] s1_pix;
  logic [PW-1:0] left_pixel, left_above_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit  <= acc_emit;
      s1_last  <= acc_last;
      s1_phase <= acc_phase;
      s1_pix   <= raw.raw_pixel;
    end
  end

  // Left neighbors move on as each request leaves stage 1, in raster order.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      left_above_pixel <= '0;
    end else if (s1_valid && adv2) begin
      left_pixel       <= s1_pix;
      left_above_pixel <= above_rd;
    end
  end

  logic [PW-1:0] tl, tr, bl, br;
  logic [PW:0]   sum_diag, sum_anti;
  logic [PW-1:0] rv, gv, bv;

  always_comb begin
    tl       = left_above_pixel;
    tr       = above_rd;
    bl       = left_pixel;
    br       = s1_pix;
    sum_anti = {1'b0, tr} + {1'b0, bl};
    sum_diag = {1'b0, tl} + {1'b0, br};
    case (bcd_pkg::phase_t'(s1_phase))
      bcd_pkg::PH_BLUE_TL: begin
        bv = tl; gv = sum_anti[PW:1]; rv = br;
      end
      bcd_pkg::PH_BLUE_TR: begin
        gv = sum_diag[PW:1]; bv = tr; rv = bl;
      end
      bcd_pkg::PH_RED_TR: begin
        gv = sum_diag[PW:1]; rv = tr; bv = bl;
      end
      default: begin
        rv = tl; gv = sum_anti[PW:1]; bv = br;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products registered, then sums and clamp.
  // ---------------------------------------------------------------------------
  logic          s2_last;
  logic [PW-1:0] s2_rv, s2_bv;
  logic [QW-1:0] q_red_g, q_red_b, q_green_g, q_green_b, q_blue_r, q_blue_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_last   <= s1_last;
      s2_rv     <= rv;
      s2_bv     <= bv;
      q_red_g   <= bcd_pkg::recip_div(gv, bcd_pkg::K_RED_G);
      q_red_b   <= bcd_pkg::recip_div(bv, bcd_pkg::K_RED_B);
      q_green_g <= bcd_pkg::recip_div(gv, bcd_pkg::K_GREEN_G);
      q_green_b <= bcd_pkg::recip_div(bv, bcd_pkg::K_GREEN_B);
      q_blue_r  <= bcd_pkg::recip_div(rv, bcd_pkg::K_BLUE_R);
      q_blue_g  <= bcd_pkg::recip_div(gv, bcd_pkg::K_BLUE_G);
    end
  end

  logic signed [SW-1:0] red_s, green_s, blue_s;

  always_comb begin
    red_s   = $signed({2'b00, s2_rv, 1'b0})
            - $signed({2'b00, q_red_g})
            - $signed({2'b00, q_red_b});
    green_s = $signed({2'b00, q_green_g})
            - $signed({4'b0000, s2_rv[PW-1:1]})
            + $signed({2'b00, q_green_b});
    blue_s  = $signed({2'b00, s2_bv, 1'b0})
            + $signed({3'b000, s2_bv})
            - $signed({2'b00, q_blue_r})
            - $signed({2'b00, q_blue_g});
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] red_q, green_q, blue_q;
  logic          last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s2_valid) begin
      red_q   <= bcd_pkg::clamp8(red_s);
      green_q <= bcd_pkg::clamp8(green_s);
      blue_q  <= bcd_pkg::clamp8(blue_s);
      last_q  <= s2_last;
    end
  end

  assign rgb.valid      = out_valid;
  assign rgb.red        = red_q;
  assign rgb.green      = green_q;
  assign rgb.blue       = blue_q;
  assign rgb.frame_last = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    c_full < eff_w)
    else $error("row store column beyond effective raw width");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rgb.valid |-> raw.ready)
    else $error("input stalled while output register is empty");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && acc_emit && acc_last |=> frame_done)
    else $error("frame not closed after last crop pixel");

  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    frame_done && !raw.frame_start |-> !acc_emit)
    else $error("result produced after frame end");

endmodule

`default_nettype wire
